FILE: hdl/deque_with_delete_by_value_core_defines.svh
// Assertion macros for the deque core.
// Included by files that carry concurrent checks; expects clk and rst in scope.
`ifndef DEQUE_WITH_DELETE_BY_VALUE_CORE_DEFINES_SVH
`define DEQUE_WITH_DELETE_BY_VALUE_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define DQD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define DQD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/dqd_pkg.sv
// Shared types and constants for the deque core.
// No dependencies.
package dqd_pkg;

  localparam int DATA_W = 32;
  localparam int LEN_W  = 5;

  typedef enum logic [1:0] {
    FN_PUSH_FRONT = 2'd0,
    FN_PUSH_BACK  = 2'd1,
    FN_POP_FRONT  = 2'd2,
    FN_DELETE     = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic              push_front;
    logic              push_back;
    logic              pop;
    logic              del;
    logic [DATA_W-1:0] item;
  } cell_ctl_t;

endpackage

FILE: hdl/dqd_if.sv
// Request and response channel interfaces for the deque core.
// Depends on dqd_pkg.
interface dqd_req_if;
  import dqd_pkg::*;
  logic              valid;
  logic              ready;
  func_t             func;
  logic [DATA_W-1:0] item_in;
  modport source (output valid, output func, output item_in, input ready);
  modport sink   (input valid, input func, input item_in, output ready);
endinterface

interface dqd_rsp_if;
  import dqd_pkg::*;
  logic              valid;
  logic              ready;
  status_t           status;
  logic [DATA_W-1:0] item_out;
  logic [LEN_W-1:0]  length_out;
  modport source (output valid, output status, output item_out, output length_out, input ready);
  modport sink   (input valid, input status, input item_out, input length_out, output ready);
endinterface

FILE: hdl/dqd_cell.sv
// One storage cell of the deque chain: holds one entry, matches the key,
// takes left/right neighbor data or the pushed item. Depends on dqd_pkg.
module dqd_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                      clk,
  input  dqd_pkg::cell_ctl_t        ctl,
  input  logic [CW-1:0]             count,
  input  logic [dqd_pkg::DATA_W-1:0] left_data,
  input  logic [dqd_pkg::DATA_W-1:0] right_data,
  input  logic                      hit_in,
  output logic [dqd_pkg::DATA_W-1:0] data,
  output logic                      hit_out
);
  import dqd_pkg::*;

  logic              occupied;
  logic              match;
  logic [DATA_W-1:0] data_next;

  assign occupied = CW'(IDX) < count;
  assign match    = occupied && (data == ctl.item);
  assign hit_out  = hit_in | match;

  always_comb begin
    data_next = data;
    if (ctl.push_front) begin
      data_next = left_data;
    end else if (ctl.push_back && (count == CW'(IDX))) begin
      data_next = ctl.item;
    end else if (ctl.pop) begin
      data_next = right_data;
    end else if (ctl.del && hit_out) begin
      data_next = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

FILE: hdl/deque_with_delete_by_value_core.sv
// Deque of item handles with delete by value, built as a chain of cells.
// Each response is registered and appears in the cycle after its request is accepted.
// Throughput: one operation per cycle while the response is not stalled; the cycle
// is set by the first-match chain that runs through all CAPACITY cells on a delete.
// Reset clears the entry count and the response valid flag and holds ready low;
// entries are not cleared. Depends on dqd_pkg, dqd_if, dqd_cell and the defines header.
`include "deque_with_delete_by_value_core_defines.svh"

module deque_with_delete_by_value_core #(
  parameter int CAPACITY = 16
) (
  input  logic     clk,
  input  logic     rst,
  dqd_req_if.sink   req,
  dqd_rsp_if.source rsp
);
  import dqd_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic              acc;
  logic              full;
  logic              empty;
  logic              nonzero;
  logic              found;
  cell_ctl_t         ctl;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  status_t           status_next;
  logic [DATA_W-1:0] item_next;
  logic              rsp_valid;
  status_t           rsp_status;
  logic [DATA_W-1:0] rsp_item;
  logic [LEN_W-1:0]  rsp_len;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic              hit [CAPACITY+1];

  assign req.ready = !rst && (!rsp_valid || rsp.ready);
  assign acc       = req.valid && req.ready;
  assign full      = count == CW'(CAPACITY);
  assign empty     = count == '0;
  assign nonzero   = req.item_in != '0;
  assign found     = hit[CAPACITY];
  assign hit[0]    = 1'b0;

  always_comb begin
    ctl.push_front = acc && (req.func == FN_PUSH_FRONT) && nonzero && !full;
    ctl.push_back  = acc && (req.func == FN_PUSH_BACK) && nonzero && !full;
    ctl.pop        = acc && (req.func == FN_POP_FRONT) && !empty;
    ctl.del        = acc && (req.func == FN_DELETE);
    ctl.item       = req.item_in;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_data;
    logic [DATA_W-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = req.item_in;
    end else begin : g_mid
      assign left_data = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end
    dqd_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count),
      .left_data  (left_data),
      .right_data (right_data),
      .hit_in     (hit[i]),
      .data       (cell_data[i]),
      .hit_out    (hit[i+1])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    item_next   = '0;
    case (req.func)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (!nonzero) begin
          status_next = ST_ZERO;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      FN_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          item_next  = cell_data[0];
          count_next = count - CW'(1);
        end
      end
      FN_DELETE: begin
        if (found) begin
          count_next = count - CW'(1);
        end else begin
          status_next = ST_NOTFOUND;
        end
      end
      default: begin
        status_next = ST_NOTFOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (acc) begin
        count <= count_next;
      end
      if (acc) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp_status <= status_next;
      rsp_item   <= item_next;
      rsp_len    <= LEN_W'(count_next);
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.item_out   = rsp_item;
  assign rsp.length_out = rsp_len;

  `DQD_ASSERT(a_count_bound, count <= CW'(CAPACITY), "count above capacity")
  `DQD_ASSERT_NEXT(a_rsp_after_accept, acc, rsp_valid, "no response after accepted beat")
  `DQD_ASSERT_NEXT(a_pop_dec, acc && (req.func == FN_POP_FRONT) && !empty,
    count == $past(count) - CW'(1), "pop did not decrement count")
  `DQD_ASSERT_NEXT(a_full_hold,
    acc && (req.func == FN_PUSH_BACK || req.func == FN_PUSH_FRONT) && full,
    $stable(count), "push to full queue changed count")

endmodule
